// ===== design/srv6css_pkg.sv =====
// Shared types and constants for the SRv6 conditional segment skip block.
// No dependencies; imported by every module of the block.
`default_nettype none

package srv6css_pkg;

    // Item commands
    localparam logic [1:0] CMD_PACKET = 2'd0;
    localparam logic [1:0] CMD_WRITE  = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;

    // Result actions
    localparam logic [1:0] ACT_PASS    = 2'd0;
    localparam logic [1:0] ACT_DROP    = 2'd1;
    localparam logic [1:0] ACT_REROUTE = 2'd2;

    // Table status codes
    localparam logic STAT_DONE = 1'b0;
    localparam logic STAT_FAIL = 1'b1;

    // Header constants
    localparam logic [7:0]  NH_ROUTING     = 8'd43;
    localparam logic [7:0]  SR_TYPE        = 8'd4;
    localparam logic [15:0] FN_SKIP_IF     = 16'h8000;
    localparam logic [15:0] FN_SKIP        = 16'h8001;
    localparam logic [15:0] IPV6_HDR_BYTES = 16'd40;
    localparam logic [15:0] SRH_BASE_BYTES = 16'd48;

    // Metric kind and comparator codes from the SID argument
    localparam logic [7:0] KIND_BW = 8'd0;
    localparam logic [7:0] CMP_EQ  = 8'd0;
    localparam logic [7:0] CMP_GT  = 8'd1;
    localparam logic [7:0] CMP_LT  = 8'd2;

    // Word carried along the cell chain. data is the destination low half on
    // packets and the metric value on writes; key is the lookup interface.
    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  key;
        logic [63:0] data;
        logic [7:0]  next_header;
        logic [7:0]  routing_type;
        logic [7:0]  segs_left;
        logic [15:0] packet_length;
        logic        hit;       // key found in some entry
        logic        cmp_ok;    // metric comparison held at the hit entry
        logic        claimed;   // write has landed in an entry
    } word_t;

endpackage

`default_nettype wire

// ===== design/srv6css_cell.sv =====
// One metric table entry plus one pipeline stage of the chain.
// Depends on srv6css_pkg.
`default_nettype none

module srv6css_cell (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 up_valid,
    input  srv6css_pkg::word_t  up_word,
    output logic                up_ready,
    output logic                down_valid,
    output srv6css_pkg::word_t  down_word,
    input  wire                 down_ready
);
    import srv6css_pkg::*;

    logic        valid_reg;
    word_t       word_reg;
    word_t       word_next;
    logic        ent_valid_reg;
    logic        ent_valid_next;
    logic [7:0]  ent_key_reg;
    logic [7:0]  ent_key_next;
    logic [63:0] ent_value_reg;
    logic [63:0] ent_value_next;
    logic        take;
    logic        match;
    logic [7:0]  cmp_code;
    logic [63:0] thr;

    assign up_ready   = !valid_reg || down_ready;
    assign take       = up_valid && up_ready;
    assign down_valid = valid_reg;
    assign down_word  = word_reg;

    assign match    = ent_valid_reg && (ent_key_reg == up_word.key);
    assign cmp_code = up_word.data[31:24];
    assign thr      = {48'd0, up_word.data[15:0]};

    always_comb
    begin
        word_next      = up_word;
        ent_valid_next = ent_valid_reg;
        ent_key_next   = ent_key_reg;
        ent_value_next = ent_value_reg;
        case (up_word.cmd)
            CMD_PACKET:
            begin
                if (match)
                begin
                    word_next.hit = 1'b1;
                    case (cmp_code)
                        CMP_EQ:  word_next.cmp_ok = (ent_value_reg == thr);
                        CMP_GT:  word_next.cmp_ok = (ent_value_reg > thr);
                        CMP_LT:  word_next.cmp_ok = (ent_value_reg < thr);
                        default: word_next.cmp_ok = 1'b0;
                    endcase
                end
            end
            CMD_WRITE:
            begin
                if (match)
                begin
                    word_next.hit = 1'b1;
                    // already placed in a lower free entry: drop the old copy
                    if (up_word.claimed)
                        ent_valid_next = 1'b0;
                    else
                    begin
                        ent_value_next    = up_word.data;
                        word_next.claimed = 1'b1;
                    end
                end
                else if (!ent_valid_reg && !up_word.claimed)
                begin
                    ent_valid_next    = 1'b1;
                    ent_key_next      = up_word.key;
                    ent_value_next    = up_word.data;
                    word_next.claimed = 1'b1;
                end
            end
            CMD_DELETE:
            begin
                if (match)
                begin
                    word_next.hit  = 1'b1;
                    ent_valid_next = 1'b0;
                end
            end
            default:
            begin
                word_next = up_word;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            ent_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                valid_reg     <= 1'b1;
                ent_valid_reg <= ent_valid_next;
            end
            else if (down_ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            word_reg      <= word_next;
            ent_key_reg   <= ent_key_next;
            ent_value_reg <= ent_value_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/srv6css_verdict.sv =====
// Final forwarding decision and output register.
// Depends on srv6css_pkg.
`default_nettype none

module srv6css_verdict (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 up_valid,
    input  srv6css_pkg::word_t  up_word,
    output logic                up_ready,
    output logic                result_valid,
    input  wire                 result_ready,
    output logic [1:0]          action,
    output logic [7:0]          next_segs_left,
    output logic                table_status
);
    import srv6css_pkg::*;

    logic        valid_reg;
    logic [1:0]  action_reg;
    logic [1:0]  action_next;
    logic [7:0]  nsl_reg;
    logic [7:0]  nsl_next;
    logic        status_reg;
    logic        status_next;
    logic        take;
    logic [15:0] func;
    logic [7:0]  skip;
    logic [7:0]  kind;
    logic        do_skip;
    logic [7:0]  nsl;
    logic [8:0]  nsl_plus;
    logic [16:0] seg_end;

    assign up_ready       = !valid_reg || result_ready;
    assign take           = up_valid && up_ready;
    assign result_valid   = valid_reg;
    assign action         = action_reg;
    assign next_segs_left = nsl_reg;
    assign table_status   = status_reg;

    assign func = up_word.data[63:48];
    assign skip = up_word.data[47:40];
    assign kind = up_word.data[39:32];

    always_comb
    begin
        action_next = ACT_PASS;
        nsl_next    = 8'd0;
        status_next = STAT_DONE;
        do_skip     = 1'b0;
        nsl         = up_word.segs_left - 8'd1;
        nsl_plus    = 9'd0;
        seg_end     = 17'd0;
        case (up_word.cmd)
            CMD_PACKET:
            begin
                if (up_word.packet_length < IPV6_HDR_BYTES)
                    action_next = ACT_DROP;
                else if (up_word.next_header != NH_ROUTING)
                    action_next = ACT_PASS;
                else if (up_word.packet_length < SRH_BASE_BYTES)
                    action_next = ACT_DROP;
                else if (up_word.routing_type != SR_TYPE)
                    action_next = ACT_DROP;
                else if (func != FN_SKIP_IF && func != FN_SKIP)
                    action_next = ACT_PASS;
                else if (func == FN_SKIP_IF && kind == KIND_BW && !up_word.hit)
                    action_next = ACT_DROP;
                else if (up_word.segs_left == 8'd0)
                    action_next = ACT_DROP;
                else
                begin
                    do_skip = (func == FN_SKIP) || (kind == KIND_BW && up_word.cmp_ok);
                    if (do_skip && nsl < skip)
                        action_next = ACT_DROP;
                    else
                    begin
                        if (do_skip)
                            nsl = nsl - skip;
                        nsl_plus = {1'b0, nsl} + 9'd1;
                        seg_end  = {1'b0, SRH_BASE_BYTES} + {4'd0, nsl_plus, 4'd0};
                        if (seg_end > {1'b0, up_word.packet_length})
                            action_next = ACT_DROP;
                        else
                        begin
                            action_next = ACT_REROUTE;
                            nsl_next    = nsl;
                        end
                    end
                end
            end
            CMD_WRITE:  status_next = up_word.claimed ? STAT_DONE : STAT_FAIL;
            CMD_DELETE: status_next = up_word.hit ? STAT_DONE : STAT_FAIL;
            default:    status_next = STAT_DONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (take)
            valid_reg <= 1'b1;
        else if (result_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            action_reg <= action_next;
            nsl_reg    <= nsl_next;
            status_reg <= status_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/srv6_conditional_segment_skip.sv =====
// Top level of the SRv6 conditional segment skip block: cell chain + verdict.
// Depends on srv6css_pkg, srv6css_cell and srv6css_verdict.
`default_nettype none

// Channel  Handshake                   Payload
// -------  --------------------------  ------------------------------------------
// item     item_valid / item_ready     cmd, next_header, routing_type,
//                                      segs_left, dest_low_half,
//                                      packet_length, table_key, table_value
// result   result_valid / result_ready action, next_segs_left, table_status
//
// One word in per cycle while item_ready is high, one result word per item, in order.
// Each item passes one stage per table cell, then the verdict register. Every
// stage has its own valid bit and pulls when the next stage is empty or
// moving, so bubbles close up under an output stall.
// Reset clears all stage valids and all entry valid bits at once; no sweep.

module srv6_conditional_segment_skip #(
    parameter int TABLE_ENTRIES = 16
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         item_valid,
    output logic        item_ready,
    input  wire  [1:0]  cmd,
    input  wire  [7:0]  next_header,
    input  wire  [7:0]  routing_type,
    input  wire  [7:0]  segs_left,
    input  wire  [63:0] dest_low_half,
    input  wire  [15:0] packet_length,
    input  wire  [7:0]  table_key,
    input  wire  [63:0] table_value,
    output logic        result_valid,
    input  wire         result_ready,
    output logic [1:0]  action,
    output logic [7:0]  next_segs_left,
    output logic        table_status
);
    import srv6css_pkg::*;

    // Chain links: link 0 is the input port, link TABLE_ENTRIES feeds the verdict.
    word_t chain_word  [TABLE_ENTRIES+1];
    logic  chain_valid [TABLE_ENTRIES+1];
    logic  chain_ready [TABLE_ENTRIES+1];

    // Packets look up the interface named in the SID argument; table items use
    // table_key. The data field carries the metric on writes, else the SID.
    always_comb
    begin
        chain_word[0].cmd           = cmd;
        chain_word[0].key           = (cmd == CMD_PACKET) ? dest_low_half[23:16] : table_key;
        chain_word[0].data          = (cmd == CMD_WRITE) ? table_value : dest_low_half;
        chain_word[0].next_header   = next_header;
        chain_word[0].routing_type  = routing_type;
        chain_word[0].segs_left     = segs_left;
        chain_word[0].packet_length = packet_length;
        chain_word[0].hit           = 1'b0;
        chain_word[0].cmp_ok        = 1'b0;
        chain_word[0].claimed       = 1'b0;
    end

    assign chain_valid[0] = item_valid;
    assign item_ready     = chain_ready[0];

    // Each cell owns one table entry. Words visit the cells in order, so every
    // entry sees the table commands in arrival order. A write lands in the
    // lowest free entry it passes, or updates its key in place; a stale copy of
    // the key further down is then dropped.
    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        srv6css_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .up_valid   (chain_valid[i]),
            .up_word    (chain_word[i]),
            .up_ready   (chain_ready[i]),
            .down_valid (chain_valid[i+1]),
            .down_word  (chain_word[i+1]),
            .down_ready (chain_ready[i+1])
        );
    end

    // Header checks, skip arithmetic and the result register.
    srv6css_verdict u_verdict (
        .clk            (clk),
        .rst_n          (rst_n),
        .up_valid       (chain_valid[TABLE_ENTRIES]),
        .up_word        (chain_word[TABLE_ENTRIES]),
        .up_ready       (chain_ready[TABLE_ENTRIES]),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .action         (action),
        .next_segs_left (next_segs_left),
        .table_status   (table_status)
    );

endmodule

`default_nettype wire
